// ----- hdl/mvd_pkg.sv -----
// ============================================================================
// mvd_pkg
// Shared types, constants and codes of the magnetic vehicle detector.
// ============================================================================
package mvd_pkg;

    // Window depth and derived widths (the window is a power of two).
    localparam int WINDOW     = 16;
    localparam int WIN_AW     = $clog2(WINDOW);
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int SAMPLE_W   = 16;
    localparam int FIX_W      = 24;
    localparam int VAR_W      = 38;
    localparam int RSUM_W     = SAMPLE_W + WIN_AW;
    localparam int RSQ_W      = 2 * SAMPLE_W - 2 + WIN_AW + 1;
    localparam int BSUM_W     = FIX_W + WIN_AW;
    localparam int BSQ_W      = 2 * FIX_W - 2 + WIN_AW + 1;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [15:0]      ALPHA_RST     = 16'd3277;
    localparam logic [VAR_W-1:0] THRESHOLD_RST = 38'd30720;
    localparam logic [15:0]      PERIOD_RST    = 16'd500;

    localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

    typedef struct packed {
        logic signed [15:0] sample_x;
        logic signed [15:0] sample_y;
        logic signed [15:0] sample_z;
        logic [31:0]        now_ms;
    } mvd_in_t;

    typedef struct packed {
        logic signed [FIX_W-1:0] filtered_x;
        logic signed [FIX_W-1:0] filtered_y;
        logic signed [FIX_W-1:0] filtered_z;
        logic signed [FIX_W-1:0] baseline_x;
        logic signed [FIX_W-1:0] baseline_y;
        logic signed [FIX_W-1:0] baseline_z;
        logic [VAR_W-1:0]        raw_variance;
        logic [VAR_W-1:0]        baseline_variance;
        logic                    detected;
        logic                    too_soon;
        logic [15:0]             vehicle_count;
        logic                    warming_up;
    } mvd_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_SQ,
        ST_VAR,
        ST_FIN
    } mvd_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              accept;
        logic              rd_en;
        logic [WIN_AW-1:0] rd_addr;
        logic              do_sq;
        logic              do_var;
        logic              do_fin;
    } mvd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_blocked;
    } mvd_status_t;

endpackage

// ----- hdl/mvd_ctrl.sv -----
// ============================================================================
// mvd_ctrl
// Controller: sequences the ring sweep and the final computation steps.
// ============================================================================
module mvd_ctrl import mvd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  mvd_status_t status,
    output mvd_cmd_t    cmd
);

    mvd_state_t        state_reg, state_next;
    logic [WIN_AW-1:0] cnt_reg, cnt_next;

    // State and sweep counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == WIN_AW'(WINDOW - 1)) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: state_next = ST_SQ;
            ST_SQ:   state_next = ST_VAR;
            ST_VAR:  state_next = ST_FIN;
            ST_FIN: begin
                if (!status.out_blocked) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_ready     = 1'b0;
        cmd         = '0;
        cmd.rd_addr = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_READ: cmd.rd_en  = 1'b1;
            ST_SQ:   cmd.do_sq  = 1'b1;
            ST_VAR:  cmd.do_var = 1'b1;
            ST_FIN:  cmd.do_fin = !status.out_blocked;
            default: cmd = '0;
        endcase
    end

endmodule

// ----- hdl/mvd_datapath.sv -----
// ============================================================================
// mvd_datapath
// Datapath: sample rings, window sums, variances, baselines and detection.
// ============================================================================
module mvd_datapath import mvd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAR_W-1:0]     cfg_data,
    input  mvd_in_t              s_data,
    input  mvd_cmd_t             cmd,
    output mvd_status_t          status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mvd_out_t             m_data
);

    // Configuration registers.
    logic [15:0]      alpha_reg;
    logic [VAR_W-1:0] thr_reg;
    logic [15:0]      period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= ALPHA_RST;
            thr_reg    <= THRESHOLD_RST;
            period_reg <= PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ALPHA:     alpha_reg  <= cfg_data[15:0];
                CFG_THRESHOLD: thr_reg    <= cfg_data;
                CFG_PERIOD:    period_reg <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // Ring memories with registered read.
    logic [3*SAMPLE_W-1:0] raw_mem [WINDOW];
    logic [FIX_W-1:0]      bz_mem  [WINDOW];
    logic [3*SAMPLE_W-1:0] raw_rd_reg;
    logic [FIX_W-1:0]      bz_rd_reg;
    logic                  rd_vld_reg;
    logic [WIN_AW-1:0]     rd_idx_reg;

    // Persistent state.
    mvd_in_t                 in_reg;
    logic [WIN_AW-1:0]       wp_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic signed [FIX_W-1:0] bx_reg, by_reg, bz_reg;
    logic signed [FIX_W-1:0] px_reg, py_reg, pz_reg;
    logic [31:0]             last_reg;
    logic [15:0]             count_reg;
    logic signed [FIX_W-1:0] base_x_new, base_y_new, base_z_new;

    // Sweep accumulators.
    logic signed [RSUM_W-1:0] sx_reg, sy_reg, sz_reg, rsum_reg;
    logic [RSQ_W-1:0]         rsq_reg;
    logic signed [BSUM_W-1:0] bsum_reg;
    logic [BSQ_W-1:0]         bsq_reg;

    // Square and product stage.
    logic signed [2*RSUM_W-1:0] rsum_sq_reg;
    logic signed [2*BSUM_W-1:0] bsum_sq_reg;
    logic signed [FIX_W+17:0]   tx_reg, ty_reg, tz_reg;

    // Variance stage.
    logic [VAR_W-1:0] rvar_reg, bvar_reg;

    // Output register.
    logic     m_valid_reg;
    mvd_out_t m_data_reg;

    // Entry values of the current read beat.
    logic                       rd_ok;
    logic signed [SAMPLE_W-1:0] ent_x, ent_y, ent_z;
    logic signed [FIX_W-1:0]    ent_b;
    logic signed [2*SAMPLE_W-1:0] zz;
    logic signed [2*FIX_W-1:0]    bb;

    assign rd_ok = rd_vld_reg && ({1'b0, rd_idx_reg} < fill_reg);
    assign ent_x = raw_rd_reg[3*SAMPLE_W-1:2*SAMPLE_W];
    assign ent_y = raw_rd_reg[2*SAMPLE_W-1:SAMPLE_W];
    assign ent_z = raw_rd_reg[SAMPLE_W-1:0];
    assign ent_b = bz_rd_reg;
    assign zz    = ent_z * ent_z;
    assign bb    = ent_b * ent_b;

    // Memory read and write ports.
    always_ff @(posedge aclk) begin
        raw_rd_reg <= raw_mem[cmd.rd_addr];
        bz_rd_reg  <= bz_mem[cmd.rd_addr];
        rd_idx_reg <= cmd.rd_addr;
        if (cmd.do_fin) begin
            raw_mem[wp_reg] <= {in_reg.sample_x, in_reg.sample_y, in_reg.sample_z};
            bz_mem[wp_reg]  <= base_z_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_en;
        end
    end

    // Input capture and accumulation over the ring.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_reg   <= s_data;
            sx_reg   <= '0;
            sy_reg   <= '0;
            sz_reg   <= '0;
            rsum_reg <= '0;
            rsq_reg  <= '0;
            bsum_reg <= '0;
            bsq_reg  <= '0;
        end else if (rd_ok) begin
            rsum_reg <= rsum_reg + RSUM_W'(ent_z);
            rsq_reg  <= rsq_reg + RSQ_W'($unsigned(zz));
            bsum_reg <= bsum_reg + BSUM_W'(ent_b);
            bsq_reg  <= bsq_reg + BSQ_W'($unsigned(bb));
            // The slot about to be overwritten leaves the mean window.
            if (rd_idx_reg != wp_reg) begin
                sx_reg <= sx_reg + RSUM_W'(ent_x);
                sy_reg <= sy_reg + RSUM_W'(ent_y);
                sz_reg <= sz_reg + RSUM_W'(ent_z);
            end
        end
    end

    // Squares of the sums and the baseline tracking products.
    always_ff @(posedge aclk) begin
        if (cmd.do_sq) begin
            rsum_sq_reg <= rsum_reg * rsum_reg;
            bsum_sq_reg <= bsum_reg * bsum_reg;
            tx_reg <= ((FIX_W+1)'(px_reg) - (FIX_W+1)'(bx_reg)) * $signed({1'b0, alpha_reg});
            ty_reg <= ((FIX_W+1)'(py_reg) - (FIX_W+1)'(by_reg)) * $signed({1'b0, alpha_reg});
            tz_reg <= ((FIX_W+1)'(pz_reg) - (FIX_W+1)'(bz_reg)) * $signed({1'b0, alpha_reg});
        end
    end

    // Variances: window * sum of squares minus square of sum, then scaling.
    logic signed [RSQ_W+WIN_AW+1:0]         rnum;
    logic signed [BSQ_W+WIN_AW+1:0]         bnum;
    logic [BSQ_W+WIN_AW+1-2*WIN_AW-8:0]     bshift;

    assign rnum   = $signed({2'b00, rsq_reg, {WIN_AW{1'b0}}})
                  - (RSQ_W+WIN_AW+2)'(rsum_sq_reg);
    assign bnum   = $signed({2'b00, bsq_reg, {WIN_AW{1'b0}}})
                  - (BSQ_W+WIN_AW+2)'(bsum_sq_reg);
    assign bshift = bnum[BSQ_W+WIN_AW+1:2*WIN_AW+8];

    always_ff @(posedge aclk) begin
        if (cmd.do_var) begin
            rvar_reg <= (|rnum[RSQ_W+WIN_AW+1:VAR_W]) ? VAR_MAX : rnum[VAR_W-1:0];
            bvar_reg <= (|bshift[$bits(bshift)-1:VAR_W]) ? VAR_MAX : bshift[VAR_W-1:0];
        end
    end

    // Final step: means, detection and baselines.
    logic signed [RSUM_W-1:0] nx, ny, nz;
    logic signed [FIX_W-1:0]  fx, fy, fz;
    logic                     warm, meet, det, soon;
    logic [VAR_W-1:0]         vdiff;
    logic [31:0]              elapsed;
    logic signed [FIX_W+17:0] tx_sh, ty_sh, tz_sh;

    assign nx = sx_reg + RSUM_W'(in_reg.sample_x);
    assign ny = sy_reg + RSUM_W'(in_reg.sample_y);
    assign nz = sz_reg + RSUM_W'(in_reg.sample_z);
    assign fx = FIX_W'((FIX_W+WIN_AW)'(nx) <<< (8 - WIN_AW));
    assign fy = FIX_W'((FIX_W+WIN_AW)'(ny) <<< (8 - WIN_AW));
    assign fz = FIX_W'((FIX_W+WIN_AW)'(nz) <<< (8 - WIN_AW));

    assign warm    = fill_reg < FILL_W'(WINDOW);
    assign vdiff   = (rvar_reg > bvar_reg) ? rvar_reg - bvar_reg : bvar_reg - rvar_reg;
    assign meet    = !warm && (vdiff >= thr_reg);
    assign elapsed = in_reg.now_ms - last_reg;
    assign det     = meet && (elapsed >= {16'd0, period_reg});
    assign soon    = meet && !det;

    assign tx_sh = tx_reg >>> 16;
    assign ty_sh = ty_reg >>> 16;
    assign tz_sh = tz_reg >>> 16;

    always_comb begin
        if (warm) begin
            base_x_new = {in_reg.sample_x, 8'd0};
            base_y_new = {in_reg.sample_y, 8'd0};
            base_z_new = {in_reg.sample_z, 8'd0};
        end else if (det) begin
            base_x_new = bx_reg;
            base_y_new = by_reg;
            base_z_new = bz_reg;
        end else begin
            base_x_new = bx_reg + FIX_W'(tx_sh);
            base_y_new = by_reg + FIX_W'(ty_sh);
            base_z_new = bz_reg + FIX_W'(tz_sh);
        end
    end

    // Persistent state update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            fill_reg  <= '0;
            bx_reg    <= '0;
            by_reg    <= '0;
            bz_reg    <= '0;
            px_reg    <= '0;
            py_reg    <= '0;
            pz_reg    <= '0;
            last_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.do_fin) begin
            wp_reg <= wp_reg + 1'b1;
            if (warm) begin
                fill_reg <= fill_reg + 1'b1;
            end
            bx_reg <= base_x_new;
            by_reg <= base_y_new;
            bz_reg <= base_z_new;
            px_reg <= fx;
            py_reg <= fy;
            pz_reg <= fz;
            if (det) begin
                last_reg  <= in_reg.now_ms;
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.do_fin) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_fin) begin
            m_data_reg.filtered_x        <= fx;
            m_data_reg.filtered_y        <= fy;
            m_data_reg.filtered_z        <= fz;
            m_data_reg.baseline_x        <= base_x_new;
            m_data_reg.baseline_y        <= base_y_new;
            m_data_reg.baseline_z        <= base_z_new;
            m_data_reg.raw_variance      <= rvar_reg;
            m_data_reg.baseline_variance <= bvar_reg;
            m_data_reg.detected          <= det;
            m_data_reg.too_soon          <= soon;
            m_data_reg.vehicle_count     <= det ? count_reg + 1'b1 : count_reg;
            m_data_reg.warming_up        <= warm;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_data             = m_data_reg;
    assign status.out_blocked = m_valid_reg && !m_ready;

endmodule

// ----- hdl/magnetic_vehicle_detector.sv -----
// ============================================================================
// magnetic_vehicle_detector
// Vehicle detector on a 3-axis magnetometer stream: window means,
// baselines, Z variances and a rate-limited detection count.
// ============================================================================
//
//  Channel   Ports                          Beat
//  input     s_valid, s_ready, s_data       one sample and its ms time
//  result    m_valid, m_ready, m_data       one result per sample
//  config    cfg_wr_en, cfg_index, cfg_data one register write
//
// After acceptance an item goes through these steps: one read of each of
// the 16 ring entries through the single memory read port, then the last
// accumulation, the squares, the variances and the result.
// The input is ready again once the result step is done, so a new sample is
// taken only after the last one is through.
// Reset (aresetn low at a clock edge) clears the control and persistent state and loads the config reset values.
// A stalled result holds the block in its last step until the beat is taken.
module magnetic_vehicle_detector import mvd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAR_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mvd_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mvd_out_t             m_data
);

    mvd_cmd_t    cmd;
    mvd_status_t status;

    // Sequencer.
    mvd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic and storage.
    mvd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef NO_ASSERTIONS
    // A result never both counts a vehicle and flags it as too soon.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.detected && m_data.too_soon))
        else $error("detected and too_soon both set");

    // Nothing is detected while the window fills.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.warming_up) |-> (!m_data.detected && !m_data.too_soon))
        else $error("detection during warm-up");

    // One sample at a time: no new beat right after one is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");
`endif

endmodule

// ----- dv/magnetic_vehicle_detector_test.sv -----
// ============================================================================
// magnetic_vehicle_detector_test
// Self-checking test of the magnetic vehicle detector: directed samples, then
// random sample streams under several register settings, with random gaps on
// both channels and every result compared against an in-bench detector model.
// ============================================================================
module magnetic_vehicle_detector_test;
    import mvd_pkg::*;

    logic           aclk;
    logic           aresetn;
    logic           cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VAR_W-1:0] cfg_data;
    logic           s_valid;
    logic           s_ready;
    mvd_in_t        s_data;
    logic           m_valid;
    logic           m_ready;
    mvd_out_t       m_data;

    magnetic_vehicle_detector i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    localparam int WATCHDOG_LIMIT = 20000;

    // Register index that maps to no register.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Detector model state.
    logic [15:0]      mdl_alpha;
    logic [VAR_W-1:0] mdl_threshold;
    logic [15:0]      mdl_period;
    longint           mdl_raw [WINDOW][3];
    longint           mdl_base_z [WINDOW];
    longint           mdl_base [3];
    longint           mdl_prev_mean [3];
    int               mdl_wp;
    int               mdl_fill;
    logic [31:0]      mdl_last_time;
    logic [15:0]      mdl_count;

    mvd_out_t expected_results [$];
    int       error_count;
    int       idle_cycles;
    bit       stall_enable;
    logic [31:0] clock_ms;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Floor division by a positive divisor.
    function automatic longint floor_div(longint v, longint d);
        if (v >= 0) return v / d;
        return -((-v + d - 1) / d);
    endfunction

    // Population variance of the ring, 8 fractional bits out, saturated.
    function automatic logic [VAR_W-1:0] window_variance(longint sum, longint unsigned sumsq,
                                                          bit scaled);
        longint unsigned mag;
        longint unsigned numer;
        longint unsigned v;
        mag = (sum < 0) ? -sum : sum;
        numer = WINDOW * sumsq - mag * mag;
        if (scaled) v = numer / (WINDOW * WINDOW * 256);
        else v = (numer * 256) / (WINDOW * WINDOW);
        if (v > VAR_MAX) v = VAR_MAX;
        return v[VAR_W-1:0];
    endfunction

    function automatic longint track_baseline(longint base, longint mean);
        return base + floor_div((mean - base) * longint'(mdl_alpha), 65536);
    endfunction

    function automatic void model_reset();
        mdl_alpha = ALPHA_RST;
        mdl_threshold = THRESHOLD_RST;
        mdl_period = PERIOD_RST;
        for (int i = 0; i < WINDOW; i++) begin
            mdl_base_z[i] = 0;
            for (int a = 0; a < 3; a++) mdl_raw[i][a] = 0;
        end
        for (int a = 0; a < 3; a++) begin
            mdl_base[a] = 0;
            mdl_prev_mean[a] = 0;
        end
        mdl_wp = 0;
        mdl_fill = 0;
        mdl_last_time = 0;
        mdl_count = 0;
    endfunction

    // Work out the result of one sample and advance the model state.
    function automatic mvd_out_t detector_step(mvd_in_t smp);
        mvd_out_t r;
        longint s [3];
        longint mean [3];
        longint rsum, bsum, sum;
        longint unsigned rsq, bsq;
        logic [VAR_W-1:0] rvar, bvar, diff;
        logic [31:0] elapsed;
        bit warm, det, soon;
        warm = mdl_fill < WINDOW;
        det = 0;
        soon = 0;
        s[0] = smp.sample_x;
        s[1] = smp.sample_y;
        s[2] = smp.sample_z;
        rsum = 0; bsum = 0; rsq = 0; bsq = 0;
        for (int i = 0; i < WINDOW; i++) begin
            rsum += mdl_raw[i][2];
            rsq += mdl_raw[i][2] * mdl_raw[i][2];
            bsum += mdl_base_z[i];
            bsq += mdl_base_z[i] * mdl_base_z[i];
        end
        rvar = window_variance(rsum, rsq, 0);
        bvar = window_variance(bsum, bsq, 1);
        for (int a = 0; a < 3; a++) mdl_raw[mdl_wp][a] = s[a];
        for (int a = 0; a < 3; a++) begin
            sum = 0;
            for (int i = 0; i < WINDOW; i++) sum += mdl_raw[i][a];
            mean[a] = floor_div(sum * 256, WINDOW);
        end
        if (!warm) begin
            diff = (rvar > bvar) ? rvar - bvar : bvar - rvar;
            if (diff >= mdl_threshold) begin
                elapsed = smp.now_ms - mdl_last_time;
                if (elapsed >= mdl_period) begin
                    det = 1;
                    mdl_count = mdl_count + 16'd1;
                    mdl_last_time = smp.now_ms;
                end else begin
                    soon = 1;
                end
            end
        end
        for (int a = 0; a < 3; a++) begin
            if (warm) mdl_base[a] = s[a] * 256;
            else if (!det) mdl_base[a] = track_baseline(mdl_base[a], mdl_prev_mean[a]);
        end
        mdl_base_z[mdl_wp] = mdl_base[2];
        for (int a = 0; a < 3; a++) mdl_prev_mean[a] = mean[a];
        mdl_wp = (mdl_wp + 1) % WINDOW;
        if (warm) mdl_fill++;
        r.filtered_x = mean[0][FIX_W-1:0];
        r.filtered_y = mean[1][FIX_W-1:0];
        r.filtered_z = mean[2][FIX_W-1:0];
        r.baseline_x = mdl_base[0][FIX_W-1:0];
        r.baseline_y = mdl_base[1][FIX_W-1:0];
        r.baseline_z = mdl_base[2][FIX_W-1:0];
        r.raw_variance = rvar;
        r.baseline_variance = bvar;
        r.detected = det;
        r.too_soon = soon;
        r.vehicle_count = mdl_count;
        r.warming_up = warm;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Send one sample beat and record its expected result. Valid stays high
    // after acceptance; it drops only for a gap or when the stream ends.
    task automatic send_sample(mvd_in_t smp);
        int gap;
        gap = stall_enable ? gap_cycles() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(detector_step(smp));
    endtask

    task automatic send_xyz(int x, int y, int z, logic [31:0] t);
        mvd_in_t smp;
        smp.sample_x = x[15:0];
        smp.sample_y = y[15:0];
        smp.sample_z = z[15:0];
        smp.now_ms = t;
        send_sample(smp);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [VAR_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ALPHA:     mdl_alpha = value[15:0];
            CFG_THRESHOLD: mdl_threshold = value;
            CFG_PERIOD:    mdl_period = value[15:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Warm-up with field extremes, then a step in Z that trips the detector.
    task automatic test_directed();
        send_xyz(-32768, 32767, -32768, 32'd0);
        send_xyz(32767, -32768, 32767, 32'd1);
        send_xyz(0, 0, 0, 32'hFFFF_FFFF);
        send_xyz(-1, 1, -1, 32'h8000_0000);
        for (int i = 0; i < 14; i++) send_xyz(100, -100, 50, 32'd10 + i);
        // A large Z swing right away is too soon, later it is counted.
        send_xyz(100, -100, 32767, 32'd40);
        send_xyz(100, -100, -32768, 32'd60);
        send_xyz(100, -100, 32767, 32'd2000);
        send_xyz(100, -100, -32768, 32'd2100);
        send_xyz(100, -100, 32767, 32'd9000);
        wait_drained();
    endtask

    // A random stream: mostly quiet samples, occasional large swings on all axes and some fully random beats.
    task automatic test_random_stream(int count);
        int level, amp;
        for (int n = 0; n < count; n++) begin
            mvd_in_t smp;
            clock_ms += $urandom_range(0, 3) == 0 ? $urandom_range(0, 1500)
                                                  : $urandom_range(0, 60);
            if ($urandom_range(0, 19) == 0) begin
                smp = mvd_in_t'(80'({$urandom(), $urandom(), $urandom()}));
            end else begin
                level = $urandom_range(0, 9) < 2 ? 20000 : 200;
                amp = $urandom_range(0, level);
                smp.sample_x = 16'($signed($urandom_range(0, 2 * amp)) - amp);
                smp.sample_y = 16'($signed($urandom_range(0, 2 * amp)) - amp);
                smp.sample_z = 16'($signed($urandom_range(0, 2 * amp)) - amp);
                smp.now_ms = clock_ms;
            end
            send_sample(smp);
        end
        wait_drained();
    endtask

    // Run through register settings including the extremes.
    task automatic test_register_sweep();
        write_register(CFG_ALPHA, 38'd65535);
        write_register(CFG_THRESHOLD, 38'd0);
        write_register(CFG_PERIOD, 38'd0);
        test_random_stream(300);
        write_register(CFG_ALPHA, 38'd0);
        write_register(CFG_THRESHOLD, VAR_MAX);
        write_register(CFG_PERIOD, 38'd65535);
        test_random_stream(250);
        write_register(CFG_ALPHA, 38'h3F_FFFF_0000 | 38'd20000);
        write_register(CFG_THRESHOLD, 38'd200000);
        write_register(CFG_PERIOD, 38'h3F_FFFF_0000 | 38'd300);
        write_register(CFG_UNUSED, 38'h15_5555_5555);
        test_random_stream(500);
        write_register(CFG_ALPHA, 38'd3277);
        write_register(CFG_THRESHOLD, 38'd30720);
        write_register(CFG_PERIOD, 38'd500);
        stall_enable = 1'b0;
        test_random_stream(200);
        stall_enable = 1'b1;
        write_register(CFG_ALPHA, 38'd40000);
        write_register(CFG_THRESHOLD, 38'd5000);
        write_register(CFG_PERIOD, 38'd100);
        test_random_stream(580);
    endtask

    // Result side: random back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !stall_enable || ($urandom_range(0, 99) < 65) ||
                       ($urandom_range(0, 99) < 20);
        end
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result beat with nothing expected: %p", $time, m_data);
                error_count++;
            end else begin
                mvd_out_t exp_r;
                exp_r = expected_results.pop_front();
                if (m_data !== exp_r) begin
                    $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                             $time, exp_r, m_data);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any beat.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[magnetic_vehicle_detector] ERROR");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        error_count = 0;
        idle_cycles = 0;
        stall_enable = 1'b1;
        clock_ms = 32'd0;
        model_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        clock_ms = 32'hFFFF_F000;
        test_register_sweep();
        if (error_count == 0) begin
            $display("[magnetic_vehicle_detector] OK");
        end else begin
            $display("[magnetic_vehicle_detector] ERROR");
        end
        $finish;
    end

endmodule
